// ===== rtl/core/lst_pkg.sv =====
// ----------------------------------------------------------------------------
// lst_pkg
// Shared types and constants for the lazy segment tree block.
// ----------------------------------------------------------------------------
`default_nettype none

package lst_pkg;

  localparam int LEAVES    = 1024;
  localparam int LEAF_AW   = $clog2(LEAVES);
  localparam int IDX_W     = LEAF_AW + 1;
  localparam int NODES     = 4 * LEAVES;
  localparam int NODE_AW   = $clog2(NODES);
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 2;
  localparam int SP_W      = $clog2(LEAF_AW + 2);
  localparam int STK_DEPTH = 2 ** SP_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_ADD   = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_ENTER,
    PH_LEFT,
    PH_RIGHT
  } phase_t;

  typedef enum logic [1:0] {
    SEL_SELF,
    SEL_LEFT,
    SEL_RIGHT
  } tag_sel_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_START,
    OP_LOAD,
    OP_LEAF_RD,
    OP_LEAF_WR,
    OP_RD_SELF,
    OP_RD_L,
    OP_RD_R,
    OP_HOLD,
    OP_TAG_SET,
    OP_TAG_RD,
    OP_TAG_MUL,
    OP_TAG_WR,
    OP_CLR_PEND,
    OP_COMB,
    OP_ACC,
    OP_DESC_L,
    OP_DESC_R,
    OP_POP,
    OP_OUT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_VISIT,
    S_POP,
    S_LEAF_RD,
    S_LEAF_WR,
    S_ACC,
    S_PUSH_CHK,
    S_PTL,
    S_PTR,
    S_PCLR,
    S_PDESC,
    S_TAG_RD,
    S_TAG_MUL,
    S_TAG_WR,
    S_CMB_R,
    S_CMB_W,
    S_OUT
  } ctl_state_t;

  typedef struct packed {
    dp_op_t   op;
    tag_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t   cmd;
    logic   tree_ok;
    logic   rng_empty;
    logic   load_ok;
    logic   leaf;
    logic   disjoint;
    logic   covered;
    phase_t phase;
    logic   pend_nz;
    logic   sp_zero;
    logic   out_busy;
  } dp_stat_t;

  typedef struct packed {
    logic [NODE_AW-1:0] nd;
    logic [IDX_W-1:0]   a;
    logic [IDX_W-1:0]   b;
    phase_t             ph;
  } frame_t;

endpackage

`default_nettype wire

// ===== rtl/core/lazy_segment_tree_range_add_sum.sv =====
// One transaction is handled at a time: in_ready is high only while the
// controller is idle, so a new transaction is taken only after the last one is done.
// Reset: synchronous, active low; length_in_use returns to 1 and no tree exists.
// ----------------------------------------------------------------------------
// lazy_segment_tree_range_add_sum
// Range-add / range-sum segment tree with lazy tags over 32-bit elements.
// ----------------------------------------------------------------------------
`default_nettype none

module lazy_segment_tree_range_add_sum (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input transactions
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [lst_pkg::CMD_W-1:0]         in_cmd,
  input  wire logic [lst_pkg::IDX_W-1:0]         in_lo_index,
  input  wire logic [lst_pkg::IDX_W-1:0]         in_hi_index,
  input  wire logic signed [lst_pkg::DATA_W-1:0] in_value,
  // result transactions
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [lst_pkg::DATA_W-1:0]      out_range_sum,
  // configuration write
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lst_pkg::IDX_W-1:0]         cfg_length_in_use
);
  import lst_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // The register write never stalls.
  assign cfg_ready = 1'b1;

  // Controller: walks the tree depth first with an explicit stack, one node
  // step at a time. Non-zero pending tags are pushed to both children before descending,
  // and add/build combine the child sums on the way back up.
  lst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // Datapath: memories, stack, tag multiply and the output register, which
  // holds a query result while the next transaction is taken.
  lst_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_length_in_use (cfg_length_in_use),
    .in_cmd            (in_cmd),
    .in_lo_index       (in_lo_index),
    .in_hi_index       (in_hi_index),
    .in_value          (in_value),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_range_sum     (out_range_sum),
    .cmd               (dp_cmd),
    .stat              (dp_stat)
  );

endmodule

`default_nettype wire

// ===== rtl/core/lst_ctrl.sv =====
// ----------------------------------------------------------------------------
// lst_ctrl
// Sequencer that walks the tree one node step at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module lst_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lst_pkg::dp_stat_t stat,
  output lst_pkg::dp_cmd_t       cmd
);
  import lst_pkg::*;

  ctl_state_t state_r, state_nxt;
  tag_sel_t   ret_r, ret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= SEL_SELF;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        unique case (stat.cmd)
          CMD_LOAD:  state_nxt = S_IDLE;
          CMD_BUILD: state_nxt = S_VISIT;
          CMD_ADD:   state_nxt = (stat.tree_ok && !stat.rng_empty) ? S_VISIT : S_IDLE;
          CMD_QUERY: state_nxt = (stat.tree_ok && !stat.rng_empty) ? S_VISIT : S_OUT;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_VISIT: begin
        unique case (stat.phase)
          PH_ENTER: begin
            if (stat.cmd == CMD_BUILD) begin
              state_nxt = stat.leaf ? S_LEAF_RD : S_VISIT;
            end else if (stat.disjoint) begin
              state_nxt = S_POP;
            end else if (stat.covered) begin
              if (stat.cmd == CMD_ADD) begin
                state_nxt = S_TAG_RD;
                ret_nxt   = SEL_SELF;
              end else begin
                state_nxt = S_ACC;
              end
            end else begin
              state_nxt = S_PUSH_CHK;
            end
          end
          PH_LEFT: state_nxt = S_VISIT;
          PH_RIGHT: state_nxt = (stat.cmd == CMD_QUERY) ? S_POP : S_CMB_R;
          default: state_nxt = S_POP;
        endcase
      end
      S_POP: begin
        if (!stat.sp_zero)                state_nxt = S_VISIT;
        else if (stat.cmd == CMD_QUERY)   state_nxt = S_OUT;
        else                              state_nxt = S_IDLE;
      end
      S_LEAF_RD:  state_nxt = S_LEAF_WR;
      S_LEAF_WR:  state_nxt = S_POP;
      S_ACC:      state_nxt = S_POP;
      S_PUSH_CHK: state_nxt = S_PTL;
      S_PTL: begin
        if (stat.pend_nz) begin
          state_nxt = S_TAG_RD;
          ret_nxt   = SEL_LEFT;
        end else begin
          state_nxt = S_VISIT;
        end
      end
      S_PTR: begin
        state_nxt = S_TAG_RD;
        ret_nxt   = SEL_RIGHT;
      end
      S_PCLR:    state_nxt = S_PDESC;
      S_PDESC:   state_nxt = S_VISIT;
      S_TAG_RD:  state_nxt = S_TAG_MUL;
      S_TAG_MUL: state_nxt = S_TAG_WR;
      S_TAG_WR: begin
        unique case (ret_r)
          SEL_SELF:  state_nxt = S_POP;
          SEL_LEFT:  state_nxt = S_PTR;
          SEL_RIGHT: state_nxt = S_PCLR;
          default:   state_nxt = S_POP;
        endcase
      end
      S_CMB_R: state_nxt = S_CMB_W;
      S_CMB_W: state_nxt = S_POP;
      S_OUT:   if (!stat.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state_r == S_IDLE);
    cmd.op   = OP_NONE;
    cmd.sel  = SEL_SELF;
    unique case (state_r)
      S_IDLE: if (in_valid) cmd.op = OP_START;
      S_DISPATCH: if (stat.cmd == CMD_LOAD) cmd.op = OP_LOAD;
      S_VISIT: begin
        unique case (stat.phase)
          PH_ENTER: begin
            if (stat.cmd == CMD_BUILD) begin
              if (!stat.leaf) cmd.op = OP_DESC_L;
            end else if (stat.disjoint) begin
              cmd.op = OP_NONE;
            end else if (stat.covered && stat.cmd == CMD_ADD) begin
              cmd.op  = OP_TAG_SET;
              cmd.sel = SEL_SELF;
            end else begin
              cmd.op = OP_RD_SELF;
            end
          end
          PH_LEFT:  cmd.op = OP_DESC_R;
          PH_RIGHT: if (stat.cmd != CMD_QUERY) cmd.op = OP_RD_L;
          default:  cmd.op = OP_NONE;
        endcase
      end
      S_POP:      if (!stat.sp_zero) cmd.op = OP_POP;
      S_LEAF_RD:  cmd.op = OP_LEAF_RD;
      S_LEAF_WR:  cmd.op = OP_LEAF_WR;
      S_ACC:      cmd.op = OP_ACC;
      S_PUSH_CHK: cmd.op = OP_HOLD;
      S_PTL: begin
        if (stat.pend_nz) begin
          cmd.op  = OP_TAG_SET;
          cmd.sel = SEL_LEFT;
        end else begin
          cmd.op = OP_DESC_L;
        end
      end
      S_PTR: begin
        cmd.op  = OP_TAG_SET;
        cmd.sel = SEL_RIGHT;
      end
      S_PCLR:    cmd.op = OP_CLR_PEND;
      S_PDESC:   cmd.op = OP_DESC_L;
      S_TAG_RD:  cmd.op = OP_TAG_RD;
      S_TAG_MUL: cmd.op = OP_TAG_MUL;
      S_TAG_WR:  cmd.op = OP_TAG_WR;
      S_CMB_R:   cmd.op = OP_RD_R;
      S_CMB_W:   cmd.op = OP_COMB;
      S_OUT:     if (!stat.out_busy) cmd.op = OP_OUT;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/lst_datapath.sv =====
// ----------------------------------------------------------------------------
// lst_datapath
// Leaf and node memories, traversal stack, tag arithmetic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lst_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  input  wire logic [lst_pkg::IDX_W-1:0]         cfg_length_in_use,
  input  wire logic [lst_pkg::CMD_W-1:0]         in_cmd,
  input  wire logic [lst_pkg::IDX_W-1:0]         in_lo_index,
  input  wire logic [lst_pkg::IDX_W-1:0]         in_hi_index,
  input  wire logic signed [lst_pkg::DATA_W-1:0] in_value,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic signed [lst_pkg::DATA_W-1:0]      out_range_sum,
  input  wire lst_pkg::dp_cmd_t                  cmd,
  output lst_pkg::dp_stat_t                      stat
);
  import lst_pkg::*;

  logic [IDX_W-1:0]   len_cfg_r, tree_len_r, eff_len;
  cmd_t               cmd_r;
  logic [IDX_W-1:0]   lo_r, hi_r;
  logic [DATA_W-1:0]  val_r;
  logic [NODE_AW-1:0] cur_nd_r;
  logic [IDX_W-1:0]   cur_a_r, cur_b_r;
  phase_t             cur_ph_r;
  frame_t             stk_r [STK_DEPTH];
  logic [SP_W-1:0]    sp_r;
  logic [IDX_W:0]     ab_sum;
  logic [IDX_W-1:0]   mid;
  logic [NODE_AW-1:0] left_nd, right_nd;

  logic [2*DATA_W-1:0] node_mem [NODES];
  logic [2*DATA_W-1:0] node_rd_r, node_wdata;
  logic [NODE_AW-1:0]  node_raddr, node_waddr;
  logic                node_re, node_we;
  logic [DATA_W-1:0]   rd_pend, rd_sum;
  logic [DATA_W-1:0]   leaf_mem [LEAVES];
  logic [DATA_W-1:0]   leaf_rd_r;

  logic [NODE_AW-1:0] tag_addr_r;
  logic [IDX_W-1:0]   tag_len_r;
  logic [DATA_W-1:0]  tag_val_r, prod_r;
  logic               tag_leaf_r;
  logic [DATA_W-1:0]  pend_hold_r, sum_hold_r, lsum_r, acc_r, out_sum_r;
  logic               out_valid_r;

  always_comb begin
    if (len_cfg_r == '0)                    eff_len = IDX_W'(1);
    else if (len_cfg_r > IDX_W'(LEAVES))    eff_len = IDX_W'(LEAVES);
    else                                    eff_len = len_cfg_r;
  end

  assign ab_sum   = {1'b0, cur_a_r} + {1'b0, cur_b_r};
  assign mid      = ab_sum[IDX_W:1];
  assign left_nd  = {cur_nd_r[NODE_AW-2:0], 1'b0};
  assign right_nd = {cur_nd_r[NODE_AW-2:0], 1'b1};
  assign rd_pend  = node_rd_r[2*DATA_W-1:DATA_W];
  assign rd_sum   = node_rd_r[DATA_W-1:0];

  // node memory port control
  always_comb begin
    node_re    = 1'b0;
    node_raddr = cur_nd_r;
    node_we    = 1'b0;
    node_waddr = cur_nd_r;
    node_wdata = '0;
    case (cmd.op)
      OP_RD_SELF: node_re = 1'b1;
      OP_RD_L: begin
        node_re    = 1'b1;
        node_raddr = left_nd;
      end
      OP_RD_R: begin
        node_re    = 1'b1;
        node_raddr = right_nd;
      end
      OP_TAG_RD: begin
        node_re    = 1'b1;
        node_raddr = tag_addr_r;
      end
      OP_TAG_WR: begin
        node_we    = 1'b1;
        node_waddr = tag_addr_r;
        node_wdata = {(tag_leaf_r ? rd_pend : rd_pend + tag_val_r), rd_sum + prod_r};
      end
      OP_LEAF_WR: begin
        node_we    = 1'b1;
        node_wdata = {{DATA_W{1'b0}}, leaf_rd_r};
      end
      OP_CLR_PEND: begin
        node_we    = 1'b1;
        node_wdata = {{DATA_W{1'b0}}, sum_hold_r};
      end
      OP_COMB: begin
        node_we    = 1'b1;
        node_wdata = {{DATA_W{1'b0}}, lsum_r + rd_sum};
      end
      default: node_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    if (node_re) node_rd_r <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && stat.load_ok)
      leaf_mem[LEAF_AW'(lo_r - IDX_W'(1))] <= val_r;
    if (cmd.op == OP_LEAF_RD)
      leaf_rd_r <= leaf_mem[LEAF_AW'(cur_a_r - IDX_W'(1))];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r   <= IDX_W'(1);
      tree_len_r  <= '0;
      out_valid_r <= 1'b0;
      sp_r        <= '0;
    end else begin
      if (cfg_valid) len_cfg_r <= cfg_length_in_use;
      // a new result replaces the one leaving in the same cycle
      if (cmd.op == OP_OUT)              out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (cmd.op) inside
        OP_START: begin
          if (cmd_t'(in_cmd) == CMD_BUILD) tree_len_r <= eff_len;
          sp_r <= '0;
        end
        OP_DESC_L, OP_DESC_R: sp_r <= sp_r + SP_W'(1);
        OP_POP:               sp_r <= sp_r - SP_W'(1);
        default:              sp_r <= sp_r;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op) inside
      OP_START: begin
        cmd_r    <= cmd_t'(in_cmd);
        lo_r     <= in_lo_index;
        hi_r     <= in_hi_index;
        val_r    <= in_value;
        acc_r    <= '0;
        cur_nd_r <= NODE_AW'(1);
        cur_a_r  <= IDX_W'(1);
        cur_b_r  <= (cmd_t'(in_cmd) == CMD_BUILD) ? eff_len : tree_len_r;
        cur_ph_r <= PH_ENTER;
      end
      OP_DESC_L: begin
        stk_r[sp_r] <= '{nd: cur_nd_r, a: cur_a_r, b: cur_b_r, ph: PH_LEFT};
        cur_nd_r    <= left_nd;
        cur_b_r     <= mid;
        cur_ph_r    <= PH_ENTER;
      end
      OP_DESC_R: begin
        stk_r[sp_r] <= '{nd: cur_nd_r, a: cur_a_r, b: cur_b_r, ph: PH_RIGHT};
        cur_nd_r    <= right_nd;
        cur_a_r     <= mid + IDX_W'(1);
        cur_ph_r    <= PH_ENTER;
      end
      OP_POP: begin
        cur_nd_r <= stk_r[sp_r - SP_W'(1)].nd;
        cur_a_r  <= stk_r[sp_r - SP_W'(1)].a;
        cur_b_r  <= stk_r[sp_r - SP_W'(1)].b;
        cur_ph_r <= stk_r[sp_r - SP_W'(1)].ph;
      end
      OP_TAG_SET: begin
        case (cmd.sel)
          SEL_LEFT: begin
            tag_addr_r <= left_nd;
            tag_len_r  <= mid - cur_a_r + IDX_W'(1);
            tag_val_r  <= pend_hold_r;
            tag_leaf_r <= (cur_a_r == mid);
          end
          SEL_RIGHT: begin
            tag_addr_r <= right_nd;
            tag_len_r  <= cur_b_r - mid;
            tag_val_r  <= pend_hold_r;
            tag_leaf_r <= ((mid + IDX_W'(1)) == cur_b_r);
          end
          default: begin
            tag_addr_r <= cur_nd_r;
            tag_len_r  <= cur_b_r - cur_a_r + IDX_W'(1);
            tag_val_r  <= val_r;
            tag_leaf_r <= (cur_a_r == cur_b_r);
          end
        endcase
      end
      OP_TAG_MUL: prod_r <= tag_val_r * DATA_W'(tag_len_r);
      OP_HOLD: begin
        pend_hold_r <= rd_pend;
        sum_hold_r  <= rd_sum;
      end
      OP_RD_R: lsum_r    <= rd_sum;
      OP_ACC:  acc_r     <= acc_r + rd_sum;
      OP_OUT:  out_sum_r <= acc_r;
      default: acc_r     <= acc_r;
    endcase
  end

  always_comb begin
    stat.cmd       = cmd_r;
    stat.tree_ok   = (tree_len_r != '0);
    stat.rng_empty = (lo_r > hi_r);
    stat.load_ok   = (lo_r != '0) && (lo_r <= eff_len);
    stat.leaf      = (cur_a_r == cur_b_r);
    stat.disjoint  = (cur_a_r > hi_r) || (cur_b_r < lo_r);
    stat.covered   = (cur_a_r >= lo_r) && (cur_b_r <= hi_r);
    stat.phase     = cur_ph_r;
    stat.pend_nz   = (pend_hold_r != '0);
    stat.sp_zero   = (sp_r == '0);
    stat.out_busy  = out_valid_r && !out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;

endmodule

`default_nettype wire

// ===== rtl/core/lst_port_check.sv =====
// ----------------------------------------------------------------------------
// lst_port_check
// Port-level checks for the lazy segment tree, attached to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lst_port_check (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [lst_pkg::DATA_W-1:0] out_range_sum,
  input wire logic                              cfg_ready
);
  import lst_pkg::*;

  // Result held while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_range_sum))
    else $error("result changed while stalled");

  // No result right after reset.
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Block goes busy after taking a transaction.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after accept");

  // Register writes never stall.
  a_cfg_rdy: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port stalled");

endmodule

bind lazy_segment_tree_range_add_sum lst_port_check u_port_check (.*);

`default_nettype wire
